// ----- src/scuc_pkg.sv -----
// -----------------------------------------------------------------------------
// Servo channel update controller package
// Shared widths, codes, reset values and helpers for the update controller.
// -----------------------------------------------------------------------------
package scuc_pkg;

   localparam int CHANNELS_DEF    = 8;
   localparam int INPUT_POSITIONS = 8;

   localparam int FUNC_W  = 2;
   localparam int COUNT_W = 4;
   localparam int POS_W   = 10;
   localparam int DUTY_W  = 22;
   localparam int INTV_W  = 8;
   localparam int CH_W    = 3;
   localparam int CMD_W   = 2;
   localparam int CSR_IDX_W = 2;

   localparam int REQ_DATA_W = ((COUNT_W + INPUT_POSITIONS * POS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((CH_W + DUTY_W + 7) / 8) * 8;

   localparam logic [POS_W-1:0] FULL_SCALE = POS_W'(1000);

   localparam logic [DUTY_W-1:0] RESET_MIN_DUTY = DUTY_W'(560000);
   localparam logic [DUTY_W-1:0] RESET_MAX_DUTY = DUTY_W'(2400000);
   localparam logic [INTV_W-1:0] RESET_INTERVAL = INTV_W'(50);

   localparam logic [FUNC_W-1:0] FUNC_DRIVE    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_STORE    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FAILSAFE = 2'd2;

   localparam logic [CMD_W-1:0] CMD_ENABLE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DUTY    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DISABLE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DUTY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DUTY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL = 2'd2;

   // Scaling: x / 1000 as (x >> 3) / 125 by an exact reciprocal.
   localparam int PROD_W        = POS_W + DUTY_W;
   localparam int DIV_PRE_SHIFT = 3;
   localparam int RECIP_W       = 30;
   localparam int RECIP_SHIFT   = 36;
   localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(549755814);
   localparam int QPROD_W       = PROD_W - DIV_PRE_SHIFT + RECIP_W;

   typedef struct packed {
      logic [DUTY_W-1:0] min_duty;
      logic [DUTY_W-1:0] span;
      logic              under;
   } scale_type;

   typedef struct packed {
      logic load;
      logic decide;
   } lane_ctl_type;

   typedef struct packed {
      logic enable;
      logic duty;
      logic drop;
   } lane_flag_type;

   function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] v);
      clamp_pos = (v > FULL_SCALE) ? FULL_SCALE : v;
   endfunction

endpackage

// ----- src/scuc_lane.sv -----
// -----------------------------------------------------------------------------
// Servo channel lane
// Holds one channel's last position, decides its commands for a frame and
// scales its position to a pulse width through a two-multiplier pipeline.
// -----------------------------------------------------------------------------
module scuc_lane #(
   parameter int LANE = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  scuc_pkg::lane_ctl_type        ctl,
   input  logic [scuc_pkg::POS_W-1:0]    pos,
   input  logic [scuc_pkg::INTV_W-1:0]   phase,
   input  scuc_pkg::scale_type           scale,
   output scuc_pkg::lane_flag_type       flags,
   output logic [scuc_pkg::DUTY_W-1:0]   duty
);

   logic [scuc_pkg::POS_W-1:0]   pos_ff;
   logic                         hit_ff;
   logic [scuc_pkg::POS_W-1:0]   last_ff;
   scuc_pkg::lane_flag_type      flags_ff;
   scuc_pkg::lane_flag_type      flags_in;
   logic [scuc_pkg::PROD_W-1:0]  prod_ff;
   logic [scuc_pkg::PROD_W-1:0]  prod_in;
   logic [scuc_pkg::QPROD_W-1:0] qprod_ff;
   logic [scuc_pkg::QPROD_W-1:0] qprod_in;
   logic [scuc_pkg::DUTY_W-1:0]  duty_ff;
   logic [scuc_pkg::DUTY_W-1:0]  duty_in;
   logic [scuc_pkg::QPROD_W-scuc_pkg::RECIP_SHIFT-1:0] quot;
   logic                         send;
   logic                         nonzero;

   always_comb begin
      nonzero = (pos_ff != '0);
      send    = (last_ff != pos_ff) || (hit_ff && nonzero);
      flags_in.enable = send && nonzero && (last_ff == '0);
      flags_in.duty   = send && nonzero;
      flags_in.drop   = send && !nonzero;

      prod_in  = scuc_pkg::PROD_W'(scale.span) * scuc_pkg::PROD_W'(pos_ff);
      qprod_in = scuc_pkg::QPROD_W'(prod_ff[scuc_pkg::PROD_W-1:scuc_pkg::DIV_PRE_SHIFT])
               * scuc_pkg::QPROD_W'(scuc_pkg::RECIP_MUL);
      quot     = qprod_ff[scuc_pkg::QPROD_W-1:scuc_pkg::RECIP_SHIFT];
      duty_in  = scale.under ? scale.min_duty
               : scuc_pkg::DUTY_W'(scale.min_duty + quot[scuc_pkg::DUTY_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         pos_ff <= pos;
         hit_ff <= (phase == scuc_pkg::INTV_W'(LANE));
      end
      prod_ff  <= prod_in;
      qprod_ff <= qprod_in;
      duty_ff  <= duty_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= '0;
         flags_ff <= '0;
      end else if (ctl.decide) begin
         last_ff  <= pos_ff;
         flags_ff <= flags_in;
      end
   end

   assign flags = flags_ff;
   assign duty  = duty_ff;

endmodule

// ----- src/scuc_merge.sv -----
// -----------------------------------------------------------------------------
// Servo command merge
// Collects the lanes' pending commands and serializes them in channel order
// through an output register, marking the final word of the frame.
// -----------------------------------------------------------------------------
module scuc_merge #(
   parameter int CHANNELS = scuc_pkg::CHANNELS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  scuc_pkg::lane_flag_type            flags [CHANNELS],
   input  logic [scuc_pkg::DUTY_W-1:0]        duty  [CHANNELS],
   output logic                               pend_any,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [scuc_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // channel, duty_ns
   output logic [scuc_pkg::CMD_W-1:0]         rsp_tuser,  // command
   output logic                               rsp_tlast
);

   localparam int PEND_W = 2 * CHANNELS;

   logic [PEND_W-1:0]           pend_ff;
   logic [PEND_W-1:0]           pend_in;
   logic [PEND_W-1:0]           load_bits;
   logic [PEND_W-1:0]           sel;
   logic                        found;
   logic                        advance;
   logic [scuc_pkg::CH_W-1:0]   ch_sel;
   logic [scuc_pkg::CMD_W-1:0]  cmd_sel;
   logic [scuc_pkg::DUTY_W-1:0] duty_sel;

   logic                        valid_ff;
   logic                        valid_in;
   logic [scuc_pkg::CH_W-1:0]   ch_ff;
   logic [scuc_pkg::CMD_W-1:0]  cmd_ff;
   logic [scuc_pkg::DUTY_W-1:0] duty_ff;
   logic                        last_ff;

   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         load_bits[2*i]   = flags[i].enable;
         load_bits[2*i+1] = flags[i].duty || flags[i].drop;
      end

      found = 1'b0;
      sel   = '0;
      for (int b = 0; b < PEND_W; b++) begin
         if (pend_ff[b] && !found) begin
            sel[b] = 1'b1;
            found  = 1'b1;
         end
      end

      ch_sel   = '0;
      cmd_sel  = scuc_pkg::CMD_ENABLE;
      duty_sel = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (sel[2*i]) begin
            ch_sel  = scuc_pkg::CH_W'(i);
            cmd_sel = scuc_pkg::CMD_ENABLE;
         end
         if (sel[2*i+1]) begin
            ch_sel = scuc_pkg::CH_W'(i);
            if (flags[i].duty) begin
               cmd_sel  = scuc_pkg::CMD_DUTY;
               duty_sel = duty[i];
            end else begin
               cmd_sel = scuc_pkg::CMD_DISABLE;
            end
         end
      end

      pend_any = (pend_ff != '0);
      advance  = pend_any && (!valid_ff || rsp_tready);

      if (load) begin
         pend_in = load_bits;
      end else if (advance) begin
         pend_in = pend_ff & ~sel;
      end else begin
         pend_in = pend_ff;
      end

      if (advance) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ch_ff   <= ch_sel;
         cmd_ff  <= cmd_sel;
         duty_ff <= duty_sel;
         last_ff <= ((pend_ff & ~sel) == '0);
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = scuc_pkg::RSP_DATA_W'({duty_ff, ch_ff});
   assign rsp_tuser  = cmd_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ----- src/servo_channel_update_controller_top.sv -----
// A drive frame (stored or live) goes to all channel lanes at once: the DECIDE
// state decides every channel's commands, then a multiply and a reciprocal
// multiply, each registered, scale positions to pulse widths while the state
// machine steps through MUL and DIV. The merge stage, loaded in DIV, sends one
// word per cycle through its output register while the output is not stalled,
// n words with n up to 2 * CHANNELS, and returns to idle once it sees itself
// empty; only then is the next frame accepted. A waiting output word can overlap
// the next frame. A store frame or an unused function is accepted without
// leaving idle and sends nothing.
// -----------------------------------------------------------------------------
// Servo channel update controller
// Turns frames of servo positions into per-channel enable, duty and disable
// commands, with failsafe storage and a periodic refresh counter.
// -----------------------------------------------------------------------------
module servo_channel_update_controller_top #(
   parameter int CHANNELS = scuc_pkg::CHANNELS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [scuc_pkg::REQ_DATA_W-1:0]     req_tdata,  // channel_count, position_0..7
   input  logic [scuc_pkg::FUNC_W-1:0]         req_tuser,  // func

   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [scuc_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // channel, duty_ns
   output logic [scuc_pkg::CMD_W-1:0]          rsp_tuser,  // command
   output logic                                rsp_tlast,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [scuc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [scuc_pkg::DUTY_W-1:0]         csr_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECIDE = 3'd1;
   localparam logic [2:0] ST_MUL    = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_SEND   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   logic [scuc_pkg::DUTY_W-1:0] min_ff;
   logic [scuc_pkg::DUTY_W-1:0] max_ff;
   logic [scuc_pkg::INTV_W-1:0] interval_ff;
   logic [scuc_pkg::INTV_W-1:0] fc_ff;
   logic [scuc_pkg::INTV_W-1:0] fc_in;

   logic [scuc_pkg::POS_W-1:0] fs_ff   [CHANNELS];
   logic [scuc_pkg::POS_W-1:0] in_pos  [CHANNELS];
   logic [scuc_pkg::POS_W-1:0] lane_pos[CHANNELS];

   scuc_pkg::lane_flag_type     lane_flags[CHANNELS];
   logic [scuc_pkg::DUTY_W-1:0] lane_duty [CHANNELS];

   logic [scuc_pkg::FUNC_W-1:0]  func;
   logic [scuc_pkg::COUNT_W-1:0] count;
   logic                         accept;
   logic                         drive;
   logic                         store;
   logic                         pend_any;
   scuc_pkg::lane_ctl_type       ctl;
   scuc_pkg::scale_type          scale;

   assign func   = req_tuser;
   assign count  = req_tdata[scuc_pkg::COUNT_W-1:0];
   assign accept = req_tvalid && req_tready;
   assign drive  = accept && ((func == scuc_pkg::FUNC_DRIVE) ||
                              (func == scuc_pkg::FUNC_FAILSAFE));
   assign store  = accept && (func == scuc_pkg::FUNC_STORE);

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;

   assign scale.min_duty = min_ff;
   assign scale.span     = max_ff - min_ff;
   assign scale.under    = (max_ff < min_ff);

   assign ctl.load   = drive;
   assign ctl.decide = (state_ff == ST_DECIDE);

   generate
      for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
         if (g < scuc_pkg::INPUT_POSITIONS) begin : g_in
            assign in_pos[g] = (scuc_pkg::COUNT_W'(g) < count)
               ? scuc_pkg::clamp_pos(req_tdata[scuc_pkg::COUNT_W + g*scuc_pkg::POS_W +:
                                               scuc_pkg::POS_W])
               : '0;
         end else begin : g_zero
            assign in_pos[g] = '0;
         end

         assign lane_pos[g] = (func == scuc_pkg::FUNC_FAILSAFE) ? fs_ff[g] : in_pos[g];

         always_ff @(posedge clock) begin
            if (reset) begin
               fs_ff[g] <= '0;
            end else if (store && (scuc_pkg::COUNT_W'(g) < count)) begin
               fs_ff[g] <= in_pos[g];
            end
         end

         scuc_lane #(
            .LANE (g)
         ) u_lane (
            .clock (clock),
            .reset (reset),
            .ctl   (ctl),
            .pos   (lane_pos[g]),
            .phase (fc_ff),
            .scale (scale),
            .flags (lane_flags[g]),
            .duty  (lane_duty[g])
         );
      end
   endgenerate

   scuc_merge #(
      .CHANNELS (CHANNELS)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (state_ff == ST_DIV),
      .flags      (lane_flags),
      .duty       (lane_duty),
      .pend_any   (pend_any),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always_comb begin
      if (({1'b0, fc_ff} + 9'd1) >= {1'b0, interval_ff}) begin
         fc_in = '0;
      end else begin
         fc_in = fc_ff + scuc_pkg::INTV_W'(1);
      end

      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (drive) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: state_in = ST_MUL;
         ST_MUL:    state_in = ST_DIV;
         ST_DIV:    state_in = ST_SEND;
         ST_SEND: begin
            if (!pend_any) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (drive) begin
            fc_ff <= fc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff      <= scuc_pkg::RESET_MIN_DUTY;
         max_ff      <= scuc_pkg::RESET_MAX_DUTY;
         interval_ff <= scuc_pkg::RESET_INTERVAL;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            scuc_pkg::CSR_MIN_DUTY: min_ff      <= csr_data;
            scuc_pkg::CSR_MAX_DUTY: max_ff      <= csr_data;
            scuc_pkg::CSR_INTERVAL: interval_ff <= csr_data[scuc_pkg::INTV_W-1:0];
            default: ;
         endcase
      end
   end

endmodule
